// File: hw/rtl/tts_pkg.sv
// Shared types, constants and the 64-bit popcount for the Tanimoto threshold screen.
// Used by tts_alu and tanimoto_threshold_screen; depends on nothing else.
`default_nettype none

package tts_pkg;

  localparam int MAX_WORDS  = 32;
  localparam int WORD_W     = 64;
  localparam int IDX_W      = 5;
  localparam int ID_W       = 64;
  localparam int CNT_W      = 12;
  localparam int POP_W      = 7;
  localparam int WIU_W      = 6;
  localparam int THR_W      = 8;

  localparam logic [CNT_W-1:0] FIELD_MAX = 12'd4095;
  localparam logic [CNT_W-1:0] QUERY_MAX = CNT_W'(MAX_WORDS * WORD_W);

  // stream payload layout
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 112;
  localparam int ACT_W      = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_NUM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS = 2'd2;

  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ROW    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BOUNDS = 2'd2;

  localparam logic KIND_HIT    = 1'b0;
  localparam logic KIND_BOUNDS = 1'b1;

  // shift-add / shift-subtract unit
  localparam int ALU_W      = 22;
  localparam int DIV_W      = 19;
  localparam int MUL_STEPS  = THR_W;
  localparam int STEP_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [THR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [ALU_W-1:0] result;
  } alu_rsp_t;

  function automatic logic [POP_W-1:0] ones64(input logic [WORD_W-1:0] v);
    logic [3:0]       byte_cnt [8];
    logic [POP_W-1:0] total;
    total = '0;
    for (int i = 0; i < 8; i++) begin
      byte_cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[i] = byte_cnt[i] + 4'(v[i*8+j]);
      end
      total = total + POP_W'(byte_cnt[i]);
    end
    return total;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tts_alu.sv
// Iterative multiply / divide unit: one shared adder, one bit per cycle.
// Multiply is shift-add over the 8-bit operand, divide is restoring. Uses tts_pkg.
`default_nettype none

module tts_alu (
  input  wire               clk,
  input  wire               rst,
  input  tts_pkg::alu_req_t req,
  output tts_pkg::alu_rsp_t rsp
);
  import tts_pkg::*;

  logic [ALU_W-1:0]      acc;
  logic [ALU_W-1:0]      sh;
  logic [THR_W-1:0]      bq;
  alu_op_t               op_r;
  logic                  running;
  logic                  done;
  logic [STEP_CNT_W-1:0] cnt;

  logic [THR_W:0]        trial;
  logic [ALU_W-1:0]      add_x;
  logic [ALU_W-1:0]      add_y;
  logic                  add_c;
  logic [ALU_W-1:0]      sum;
  logic                  neg;

  always_comb begin
    trial = {acc[THR_W-1:0], sh[DIV_W-1]};
    if (op_r == ALU_MUL) begin
      add_x = acc;
      add_y = bq[0] ? sh : '0;
      add_c = 1'b0;
    end else begin
      // trial minus divisor in two's complement
      add_x = ALU_W'(trial);
      add_y = ~ALU_W'(bq);
      add_c = 1'b1;
    end
    sum = add_x + add_y + ALU_W'(add_c);
    neg = sum[ALU_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_r    <= req.op;
        acc     <= '0;
        sh      <= req.a;
        bq      <= req.b;
        cnt     <= (req.op == ALU_MUL) ? STEP_CNT_W'(MUL_STEPS) : STEP_CNT_W'(DIV_W);
        running <= 1'b1;
      end else if (running) begin
        case (op_r)
          ALU_MUL: begin
            acc <= sum;
            sh  <= {sh[ALU_W-2:0], 1'b0};
            bq  <= {1'b0, bq[THR_W-1:1]};
          end
          ALU_DIV: begin
            acc <= neg ? ALU_W'(trial) : sum;
            sh  <= {sh[ALU_W-2:0], ~neg};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - STEP_CNT_W'(1);
        if (cnt == STEP_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op_r == ALU_MUL) ? acc : ALU_W'(sh[DIV_W-1:0]);

endmodule

`default_nettype wire

// File: hw/rtl/tanimoto_threshold_screen.sv
// Top level of the Tanimoto threshold screen: query store, overlap counting,
// sequencer and output register. Uses tts_pkg and tts_alu.
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | s_tdata, s_tuser = action, s_tlast = last_word
//  m_*     | out | m_tvalid / m_tready    | m_tdata, m_tuser = kind
//  cfg_*   | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// A query word passes through S_QPOP and a row word that is not the last through S_DPOP.
// A row's last word runs two products and a bounds request two products and two quotients,
// all through tts_alu at one bit per cycle.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken, and a full register stalls the sequencer.
// Reset is synchronous; the query store has no clearing pass and is valid once written.
`default_nettype none

module tanimoto_threshold_screen (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // word_index[4:0], word_value[68:5], row_id[132:69], row_popcount[144:133], zero pad
  input  wire  [tts_pkg::IN_DATA_W-1:0]     s_tdata,
  // action[1:0]
  input  wire  [tts_pkg::ACT_W-1:0]         s_tuser,
  input  wire                               s_tlast,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // hit_id[63:0], intersection[75:64], union_size[87:76], lower_bound[99:88],
  // upper_bound[111:100]
  output logic [tts_pkg::OUT_DATA_W-1:0]    m_tdata,
  // kind[0]
  output logic                              m_tuser,
  input  wire                               cfg_we,
  input  wire  [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QPOP,
    S_DPOP,
    S_UNI,
    S_MUL_L,
    S_MUL_R,
    S_BND,
    S_LO_MUL,
    S_LO_DIV,
    S_HI_MUL,
    S_HI_DIV,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [THR_W-1:0] thr_num;
  logic [THR_W-1:0] thr_den;
  logic [WIU_W-1:0] wiu;

  // item fields held for the work
  logic [ACT_W-1:0]  act_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WORD_W-1:0] word_r;
  logic [ID_W-1:0]   id_r;
  logic [CNT_W-1:0]  rpc_r;
  logic              last_r;
  logic              rng_r;

  logic [CNT_W-1:0]  q_ones;
  logic [CNT_W-1:0]  ov;
  logic [CNT_W-1:0]  inter_r;
  logic [CNT_W:0]    uni_r;
  logic [ALU_W-1:0]  lhs_r;
  logic [CNT_W-1:0]  lo_r;
  logic              kind_r;

  logic [WORD_W-1:0] qmem [MAX_WORDS];
  logic [WORD_W-1:0] qmem_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              s_fire;
  logic [IDX_W-1:0]  s_idx;
  logic              s_rng;
  logic [ACT_W-1:0]  s_act;

  logic [POP_W-1:0]  pop;
  logic [CNT_W:0]    q_sum;
  logic [CNT_W:0]    ov_sum;
  logic [CNT_W-1:0]  ov_sat;
  logic signed [CNT_W+1:0] uni_full;
  logic [CNT_W:0]    uni_clamp;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  lo_val;
  logic [CNT_W-1:0]  hi_val;
  logic [CNT_W-1:0]  uni_out;
  logic              out_free;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid & s_tready;
  assign s_idx    = s_tdata[IDX_W-1:0];
  assign s_act    = s_tuser;
  assign s_rng    = ({1'b0, s_idx} < wiu);
  assign out_free = ~m_tvalid | m_tready;

  tts_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // query store: written by in-range query beats, read once per accepted beat
  always_ff @(posedge clk) begin
    if (s_fire && (s_act == ACT_QUERY) && s_rng) begin
      qmem[s_idx] <= s_tdata[IDX_W +: WORD_W];
    end
    if (s_fire) begin
      qmem_rdata <= qmem[s_idx];
    end
  end

  always_comb begin
    pop       = ones64((act_r == ACT_ROW) ? (word_r & qmem_rdata) : word_r);
    q_sum     = ((idx_r == '0) ? (CNT_W+1)'(0) : {1'b0, q_ones}) + (CNT_W+1)'(pop);
    ov_sum    = {1'b0, ov} + (CNT_W+1)'(pop);
    ov_sat    = ov_sum[CNT_W] ? FIELD_MAX : ov_sum[CNT_W-1:0];
    uni_full  = $signed({2'b00, q_ones}) + $signed({2'b00, rpc_r})
              - $signed({2'b00, inter_r});
    uni_clamp = (uni_full < 14'sd1) ? (CNT_W+1)'(1) : uni_full[CNT_W:0];
    uni_out   = uni_r[CNT_W] ? FIELD_MAX : uni_r[CNT_W-1:0];
    cap       = {wiu, 6'b000000};
    lo_val    = (alu_rsp.result > ALU_W'(FIELD_MAX)) ? FIELD_MAX
              : alu_rsp.result[CNT_W-1:0];
    hi_val    = (alu_rsp.result > ALU_W'(cap)) ? cap : alu_rsp.result[CNT_W-1:0];
  end

  // requests to the shared unit, one start pulse per operation
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state)
      S_UNI: begin
        alu_req.start = 1'b1;
        alu_req.a     = ALU_W'(inter_r);
        alu_req.b     = thr_den;
      end
      S_MUL_L: begin
        alu_req.start = alu_rsp.done;
        alu_req.a     = ALU_W'(uni_r);
        alu_req.b     = thr_num;
      end
      S_BND: begin
        alu_req.start = 1'b1;
        alu_req.a     = ALU_W'(q_ones);
        alu_req.b     = thr_num;
      end
      S_LO_MUL: begin
        // ceiling: add den - 1 before dividing
        alu_req.start = alu_rsp.done;
        alu_req.op    = ALU_DIV;
        alu_req.a     = alu_rsp.result + ALU_W'(thr_den) - ALU_W'(1);
        alu_req.b     = thr_den;
      end
      S_LO_DIV: begin
        alu_req.start = alu_rsp.done;
        alu_req.a     = ALU_W'(q_ones);
        alu_req.b     = thr_den;
      end
      S_HI_MUL: begin
        alu_req.start = alu_rsp.done;
        alu_req.op    = ALU_DIV;
        alu_req.a     = alu_rsp.result;
        alu_req.b     = thr_num;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_num <= 8'd7;
      thr_den <= 8'd10;
      wiu     <= WIU_W'(MAX_WORDS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM: begin
          thr_num <= (cfg_data == '0) ? THR_W'(1) : cfg_data;
        end
        REG_DEN: begin
          thr_den <= (cfg_data == '0) ? THR_W'(1) : cfg_data;
        end
        REG_WORDS: begin
          if (cfg_data[WIU_W-1:0] == '0) begin
            wiu <= WIU_W'(1);
          end else if (cfg_data[WIU_W-1:0] > WIU_W'(MAX_WORDS)) begin
            wiu <= WIU_W'(MAX_WORDS);
          end else begin
            wiu <= cfg_data[WIU_W-1:0];
          end
        end
        default: begin
          wiu <= wiu;
        end
      endcase
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      q_ones   <= '0;
      ov       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // the emit state loads the register itself
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            act_r  <= s_act;
            idx_r  <= s_idx;
            word_r <= s_tdata[IDX_W +: WORD_W];
            id_r   <= s_tdata[IDX_W+WORD_W +: ID_W];
            rpc_r  <= s_tdata[IDX_W+WORD_W+ID_W +: CNT_W];
            last_r <= s_tlast;
            rng_r  <= s_rng;
            case (s_act)
              ACT_QUERY:  state <= S_QPOP;
              ACT_ROW:    state <= S_DPOP;
              ACT_BOUNDS: state <= S_BND;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_QPOP: begin
          if (rng_r) begin
            q_ones <= (q_sum > (CNT_W+1)'(QUERY_MAX)) ? QUERY_MAX : q_sum[CNT_W-1:0];
          end
          state <= S_IDLE;
        end
        S_DPOP: begin
          if (last_r) begin
            // close the row; a word beyond the fingerprint adds nothing
            inter_r <= rng_r ? ov_sat : ov;
            ov      <= '0;
            state   <= S_UNI;
          end else begin
            if (rng_r) begin
              ov <= ov_sat;
            end
            state <= S_IDLE;
          end
        end
        S_UNI: begin
          uni_r <= uni_clamp;
          state <= S_MUL_L;
        end
        S_MUL_L: begin
          if (alu_rsp.done) begin
            lhs_r <= alu_rsp.result;
            state <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          if (alu_rsp.done) begin
            if (lhs_r >= alu_rsp.result) begin
              kind_r <= KIND_HIT;
              state  <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_BND: begin
          state <= S_LO_MUL;
        end
        S_LO_MUL: begin
          if (alu_rsp.done) begin
            state <= S_LO_DIV;
          end
        end
        S_LO_DIV: begin
          if (alu_rsp.done) begin
            lo_r  <= lo_val;
            state <= S_HI_MUL;
          end
        end
        S_HI_MUL: begin
          if (alu_rsp.done) begin
            state <= S_HI_DIV;
          end
        end
        S_HI_DIV: begin
          if (alu_rsp.done) begin
            // hold the upper bound in inter_r until the beat is built
            inter_r <= hi_val;
            kind_r  <= KIND_BOUNDS;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= kind_r;
            if (kind_r == KIND_HIT) begin
              m_tdata <= {CNT_W'(0), CNT_W'(0), uni_out, inter_r, id_r};
            end else begin
              m_tdata <= {inter_r, lo_r, CNT_W'(0), CNT_W'(0), ID_W'(0)};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks

  a_query_ones_cap: assert property (@(posedge clk) disable iff (rst)
    q_ones <= QUERY_MAX)
    else $error("query popcount above fingerprint size");

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_act == ACT_ROW) && s_tlast) |=> ##1 (ov == '0))
    else $error("overlap not cleared after last row beat");

  a_alu_done_waited: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_MUL_L || state == S_MUL_R || state == S_LO_MUL ||
                      state == S_LO_DIV || state == S_HI_MUL || state == S_HI_DIV))
    else $error("arithmetic result arrived outside a wait state");

endmodule

`default_nettype wire
